>>> hdl/sat_pkg.sv
// Shared constants, codes, control struct and encoder function for the sorted array table.
`default_nettype none
package sat_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_FIND   = 2'd2;
    localparam logic [1:0] FN_GET    = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_BULK     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    // Broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic             cmp_en;
        logic             exec_en;
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    // Index of the lowest set bit.
    function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] v);
        logic [IDX_W-1:0] res;
        res = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (v[i]) res = IDX_W'(i);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> hdl/sat_cell.sv
// One cell of the table chain: holds one entry, compares it to the key and shifts.
`default_nettype none
module sat_cell (
    input  wire                      i_clk,
    input  wire sat_pkg::t_cell_ctl  i_ctl,
    input  wire [sat_pkg::IDX_W-1:0] i_idx,
    input  wire [sat_pkg::KEY_W-1:0] i_left,
    input  wire [sat_pkg::KEY_W-1:0] i_right,
    output logic [sat_pkg::KEY_W-1:0] o_entry,
    output logic                      o_gt,
    output logic                      o_eq
);
    import sat_pkg::*;

    logic [KEY_W-1:0] r_entry;
    logic [KEY_W-1:0] n_entry;
    logic             r_gt;
    logic             n_gt;
    logic             r_eq;
    logic             n_eq;
    logic [CNT_W-1:0] w_idx;
    logic             w_valid;

    assign w_idx   = CNT_W'(i_idx);
    assign w_valid = w_idx < i_ctl.count;

    always_comb begin
        n_gt = r_gt;
        n_eq = r_eq;
        if (i_ctl.cmp_en) begin
            n_gt = w_valid && (r_entry > i_ctl.key);
            n_eq = w_valid && (r_entry == i_ctl.key);
        end
    end

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.exec_en) begin
            if (i_ctl.ins) begin
                if (i_idx == i_ctl.pos) begin
                    n_entry = i_ctl.key;
                end else if (i_idx > i_ctl.pos && w_idx <= i_ctl.count) begin
                    n_entry = i_left;
                end
            end else if (i_ctl.rem) begin
                // pull from the right neighbor at and above the removed slot
                if (i_idx >= i_ctl.pos && (w_idx + CNT_W'(1)) < i_ctl.count) begin
                    n_entry = i_right;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_gt    <= n_gt;
        r_eq    <= n_eq;
    end

    assign o_entry = r_entry;
    assign o_gt    = r_gt;
    assign o_eq    = r_eq;

endmodule
`default_nettype wire

>>> hdl/sorted_array_table.sv
// Top level of the sorted array table: sequencer, count, result register and the cell chain.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_func, i_index, i_value, i_in_bulk
//   out     | output    | o_out_valid / i_out_stall | o_status, o_found_index, o_read_value, o_count
//   cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (sorted_mode)
//
// A word passes through accept, compare in every cell, then encode and shift.
// A sorted insert or find that is not a bulk word adds a binary search over the greater-than
// flags, one halving a cycle, between the compare step and the encode and shift step.
// A new word is accepted while the previous result still waits in the output register;
// the shift step waits only until that register is free.
// Reset clears the entry count, the mode and the handshake state; entries hold no reset.
`default_nettype none
module sorted_array_table (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire [1:0]                i_func,
    input  wire [sat_pkg::IDX_W-1:0] i_index,
    input  wire [sat_pkg::KEY_W-1:0] i_value,
    input  wire                      i_in_bulk,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic [2:0]               o_status,
    output logic [sat_pkg::IDX_W-1:0] o_found_index,
    output logic [sat_pkg::KEY_W-1:0] o_read_value,
    output logic [sat_pkg::CNT_W-1:0] o_count,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire                      i_cfg_data
);
    import sat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_SRCH = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_sorted;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_func;
    logic [IDX_W-1:0] r_idx;
    logic [KEY_W-1:0] r_key;
    logic             r_bulk;
    logic [IDX_W-1:0] r_pos_rg, n_pos_rg;
    logic [KEY_W-1:0] r_rd;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;

    logic             r_out_valid;
    logic [2:0]       r_status;
    logic [IDX_W-1:0] r_pos;
    logic [KEY_W-1:0] r_rd_out;

    logic                w_in_fire;
    logic                w_exec_fire;
    logic                w_search;
    logic [CNT_W-1:0]    w_mid;
    logic [IDX_W-1:0]    w_last;
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_eq;
    logic [KEY_W-1:0]    w_entry [CAPACITY];
    t_cell_ctl           w_ctl;

    logic [2:0]       x_status;
    logic [IDX_W-1:0] x_pos;
    logic [KEY_W-1:0] x_rd;
    logic             x_ins;
    logic             x_rem;
    logic             w_any;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_exec_fire = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign w_any       = |w_eq;
    assign w_search    = r_sorted && !r_bulk && (r_func == FN_INSERT || r_func == FN_FIND);
    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_last      = IDX_W'(r_lo - CNT_W'(1));

    // position for remove and get (clamped for remove only), registered during the compare step
    always_comb begin
        if (r_func == FN_REMOVE && CNT_W'(r_idx) >= r_count) begin
            n_pos_rg = IDX_W'(r_count - CNT_W'(1));
        end else begin
            n_pos_rg = r_idx;
        end
    end

    // upper bound by halving over the registered greater-than flags
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (r_state == S_CMP) begin
            n_lo = '0;
            n_hi = r_count;
        end else if (r_state == S_SRCH && r_lo < r_hi) begin
            if (w_gt[w_mid[IDX_W-1:0]]) n_hi = w_mid;
            else                        n_lo = w_mid + CNT_W'(1);
        end
    end

    always_comb begin
        x_status = ST_OK;
        x_pos    = '0;
        x_rd     = '0;
        x_ins    = 1'b0;
        x_rem    = 1'b0;
        case (r_func)
            FN_INSERT: begin
                if (r_bulk) begin
                    x_status = ST_BULK;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    x_status = ST_FULL;
                end else begin
                    x_ins = 1'b1;
                    if (r_sorted) begin
                        x_pos = r_lo[IDX_W-1:0];
                    end else if (CNT_W'(r_idx) < r_count) begin
                        x_pos = r_idx;
                    end else begin
                        x_pos = r_count[IDX_W-1:0];
                    end
                end
            end
            FN_REMOVE: begin
                if (r_count == '0) begin
                    x_status = ST_RANGE;
                end else begin
                    x_rem = 1'b1;
                    x_pos = r_pos_rg;
                    x_rd  = r_rd;
                end
            end
            FN_FIND: begin
                if (r_bulk) begin
                    x_status = ST_BULK;
                end else if (r_sorted) begin
                    // last equal key sits just below the upper bound
                    if (r_lo != '0 && w_eq[w_last]) begin
                        x_pos = w_last;
                    end else begin
                        x_status = ST_NOTFOUND;
                    end
                end else if (!w_any) begin
                    x_status = ST_NOTFOUND;
                end else begin
                    x_pos = first_set(w_eq);
                end
            end
            default: begin
                if (CNT_W'(r_idx) >= r_count) begin
                    x_status = ST_RANGE;
                end else begin
                    x_pos = r_idx;
                    x_rd  = r_rd;
                end
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_exec_fire && x_ins)      n_count = r_count + CNT_W'(1);
        else if (w_exec_fire && x_rem) n_count = r_count - CNT_W'(1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_fire) n_state = S_CMP;
            S_CMP:   n_state = w_search ? S_SRCH : S_EXEC;
            S_SRCH:  if (n_lo >= n_hi) n_state = S_EXEC;
            S_EXEC:  if (w_exec_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_ctl.cmp_en  = (r_state == S_CMP);
    assign w_ctl.exec_en = w_exec_fire;
    assign w_ctl.ins     = x_ins;
    assign w_ctl.rem     = x_rem;
    assign w_ctl.pos     = x_pos;
    assign w_ctl.count   = r_count;
    assign w_ctl.key     = r_key;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] w_left;
        logic [KEY_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        sat_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_gt    (w_gt[g]),
            .o_eq    (w_eq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sorted    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) r_sorted <= i_cfg_data;
            if (w_exec_fire)                r_out_valid <= 1'b1;
            else if (!i_out_stall)          r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_func <= i_func;
            r_idx  <= i_index;
            r_key  <= i_value;
            r_bulk <= i_in_bulk;
        end
        if (r_state == S_CMP) begin
            r_pos_rg <= n_pos_rg;
            r_rd     <= w_entry[n_pos_rg];
        end
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (w_exec_fire) begin
            r_status <= x_status;
            r_pos    <= x_pos;
            r_rd_out <= x_rd;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_pos;
    assign o_read_value  = r_rd_out;
    assign o_count       = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EXEC)
        else $error("result appeared without a shift step");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_found_index == '0 && o_read_value == '0))
        else $error("error result carries nonzero payload");

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec_fire |=> (r_state == S_IDLE && o_out_valid))
        else $error("shift step did not complete the word");

endmodule
`default_nettype wire

>>> bench/sat_checker.sv
// Result checker for the sorted array table: tracks the key store and compares each output word.
module sat_checker (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    input  wire                        i_in_stall,
    input  wire [1:0]                  i_func,
    input  wire [sat_pkg::IDX_W-1:0]   i_index,
    input  wire [sat_pkg::KEY_W-1:0]   i_value,
    input  wire                        i_in_bulk,
    input  wire                        i_out_valid,
    input  wire                        i_out_stall,
    input  wire [2:0]                  i_status,
    input  wire [sat_pkg::IDX_W-1:0]   i_found_index,
    input  wire [sat_pkg::KEY_W-1:0]   i_read_value,
    input  wire [sat_pkg::CNT_W-1:0]   i_count,
    input  wire                        i_cfg_valid,
    input  wire                        i_cfg_ready,
    input  wire                        i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);
    import sat_pkg::*;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] slot;
        logic [KEY_W-1:0] data;
        logic [CNT_W-1:0] fill;
    } t_result;

    logic [KEY_W-1:0] keys [CAPACITY];
    int               fill_level = 0;
    logic             sorted_mode = 1'b0;
    t_result          expected_q [$];
    t_result          got;
    t_result          want;
    int               mismatches = 0;

    // First position whose key is greater than the search key.
    function automatic int upper_pos(input logic [KEY_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = fill_level;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key < keys[mid]) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    // Apply one operation to the tracked store and return the word it should produce.
    function automatic t_result apply_op(input logic [1:0] fn, input logic [IDX_W-1:0] ix,
                                         input logic [KEY_W-1:0] key, input logic bulk);
        t_result r;
        int      pos;
        int      u;
        r = '0;
        r.status = ST_OK;
        case (fn)
            FN_INSERT: begin
                if (bulk) begin
                    r.status = ST_BULK;
                end else if (fill_level >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    if (sorted_mode) pos = upper_pos(key);
                    else pos = (ix < fill_level) ? int'(ix) : fill_level;
                    for (int i = fill_level; i > pos; i--) keys[i] = keys[i-1];
                    keys[pos] = key;
                    fill_level++;
                    r.slot = IDX_W'(pos);
                end
            end
            FN_REMOVE: begin
                if (fill_level == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    pos = (ix < fill_level) ? int'(ix) : fill_level - 1;
                    r.data = keys[pos];
                    for (int i = pos; i + 1 < fill_level; i++) keys[i] = keys[i+1];
                    fill_level--;
                    r.slot = IDX_W'(pos);
                end
            end
            FN_FIND: begin
                if (bulk) begin
                    r.status = ST_BULK;
                end else begin
                    r.status = ST_NOTFOUND;
                    if (sorted_mode) begin
                        // last equal key sits just below the upper bound
                        u = upper_pos(key);
                        if (u > 0 && keys[u-1] == key) begin
                            r.status = ST_OK;
                            r.slot = IDX_W'(u - 1);
                        end
                    end else begin
                        for (int i = 0; i < fill_level; i++) begin
                            if (r.status != ST_OK && keys[i] == key) begin
                                r.status = ST_OK;
                                r.slot = IDX_W'(i);
                            end
                        end
                    end
                end
            end
            default: begin
                if (ix >= fill_level) begin
                    r.status = ST_RANGE;
                end else begin
                    r.slot = ix;
                    r.data = keys[ix];
                end
            end
        endcase
        r.fill = CNT_W'(fill_level);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_level = 0;
            sorted_mode = 1'b0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_found_index, i_read_value, i_count};
                if (expected_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected word: status=%0d index=%0d data=%h count=%0d",
                                 got.status, got.slot, got.data, got.fill);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.data !== want.data || got.fill !== want.fill) begin
                        if (mismatches < 10)
                            $display({"mismatch: expected status=%0d index=%0d data=%h count=%0d",
                                      " got status=%0d index=%0d data=%h count=%0d"},
                                     want.status, want.slot, want.data, want.fill,
                                     got.status, got.slot, got.data, got.fill);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) sorted_mode = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(apply_op(i_func, i_index, i_value, i_in_bulk));
        end
        o_pending <= expected_q.size();
        o_errors <= mismatches;
    end

endmodule

>>> bench/tb_sorted_array_table.sv
// Testbench top for the sorted array table: clock, reset, stimulus and the final verdict.
module tb_sorted_array_table;
    import sat_pkg::*;

    localparam int RUN_LIMIT = 200000;

    typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIX} t_burst;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       func;
    logic [IDX_W-1:0] index;
    logic [KEY_W-1:0] value;
    logic             in_bulk;
    logic             out_valid;
    logic             out_stall;
    logic [2:0]       status;
    logic [IDX_W-1:0] found_index;
    logic [KEY_W-1:0] read_value;
    logic [CNT_W-1:0] count;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_data;

    int errors;
    int pending;
    int send_idle_pct = 36;
    int recv_stall_pct = 60;
    int cycles = 0;

    sorted_array_table i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_func        (func),
        .i_index       (index),
        .i_value       (value),
        .i_in_bulk     (in_bulk),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_found_index (found_index),
        .o_read_value  (read_value),
        .o_count       (count),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    sat_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_func        (func),
        .i_index       (index),
        .i_value       (value),
        .i_in_bulk     (in_bulk),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_found_index (found_index),
        .i_read_value  (read_value),
        .i_count       (count),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one word after a random gap and hold it until accepted.
    task automatic send_word(input logic [1:0] fn, input logic [IDX_W-1:0] ix,
                             input logic [KEY_W-1:0] key, input logic bulk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        index <= ix;
        value <= key;
        in_bulk <= bulk;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_mode(input logic sorted);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= sorted;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Empty the table so that sorted mode starts from ordered contents.
    task automatic drain_table();
        repeat (CAPACITY) send_word(FN_REMOVE, IDX_W'($urandom_range(CAPACITY - 1)),
                                    $urandom(), 1'($urandom_range(1)));
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {KEY_W{1'b1}};
            2:       return KEY_W'(1) << $urandom_range(KEY_W - 1);
            3, 4, 5, 6: return KEY_W'($urandom_range(15));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [1:0] pick_func(input t_burst kind);
        int r;
        r = $urandom_range(99);
        case (kind)
            BURST_FILL:  return r < 90 ? FN_INSERT : r < 94 ? FN_REMOVE : r < 97 ? FN_FIND : FN_GET;
            BURST_DRAIN: return r < 65 ? FN_REMOVE : r < 75 ? FN_INSERT : r < 88 ? FN_FIND : FN_GET;
            default:     return r < 30 ? FN_INSERT : r < 55 ? FN_REMOVE : r < 80 ? FN_FIND : FN_GET;
        endcase
    endfunction

    // Run randomly chosen fill, drain and mixed bursts so the table swings between empty and full.
    task automatic run_random(input int total);
        int     left;
        int     len;
        int     r;
        t_burst kind;
        left = total;
        while (left > 0) begin
            r = $urandom_range(99);
            kind = r < 40 ? BURST_FILL : r < 65 ? BURST_DRAIN : BURST_MIX;
            len = (kind == BURST_FILL) ? $urandom_range(110, 60) : $urandom_range(60, 15);
            for (int j = 0; j < len && left > 0; j++) begin
                send_word(pick_func(kind), IDX_W'($urandom_range(CAPACITY - 1)), pick_key(),
                          $urandom_range(99) < 8);
                left--;
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FN_INSERT;
        index = '0;
        value = '0;
        in_bulk = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);

        // positional mode: empty table, bulk refusal, clamped insert and remove
        send_word(FN_REMOVE, 0, 0, 1'b0);
        send_word(FN_GET, 0, 0, 1'b0);
        send_word(FN_FIND, 0, 0, 1'b0);
        send_word(FN_INSERT, 0, 5, 1'b1);
        send_word(FN_FIND, 0, 5, 1'b1);
        send_word(FN_INSERT, 63, 0, 1'b0);
        send_word(FN_INSERT, 0, {KEY_W{1'b1}}, 1'b0);
        send_word(FN_INSERT, 1, 32'h8000_0001, 1'b0);
        send_word(FN_INSERT, 63, {KEY_W{1'b1}}, 1'b0);
        send_word(FN_FIND, 63, {KEY_W{1'b1}}, 1'b0);
        send_word(FN_FIND, 0, 32'h0000_1234, 1'b0);
        send_word(FN_GET, 63, 0, 1'b0);
        send_word(FN_GET, 3, 0, 1'b0);
        send_word(FN_REMOVE, 63, 0, 1'b1);
        send_word(FN_REMOVE, 0, 0, 1'b0);

        // sorted mode: equal keys, extremes, last-equal find
        drain_table();
        write_mode(1'b1);
        send_word(FN_INSERT, 0, 7, 1'b0);
        send_word(FN_INSERT, 0, 7, 1'b0);
        send_word(FN_INSERT, 63, 0, 1'b0);
        send_word(FN_INSERT, 5, {KEY_W{1'b1}}, 1'b0);
        send_word(FN_INSERT, 63, 3, 1'b0);
        send_word(FN_FIND, 0, 7, 1'b0);
        send_word(FN_FIND, 0, 4, 1'b0);
        send_word(FN_FIND, 0, {KEY_W{1'b1}}, 1'b0);
        send_word(FN_FIND, 0, 0, 1'b0);
        send_word(FN_GET, 0, 0, 1'b0);

        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_stall_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_stall_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            write_mode(1'b0);
            run_random(145);
            drain_table();
            write_mode(1'b1);
            run_random(145);
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
